// ===== design/interleaved_bitplane_to_chunky_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the interleaved bitplane to chunky converter
// Shared concurrent assertion forms used by the design modules.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_BITPLANE_TO_CHUNKY_TOP_ASSERT_SVH
`define INTERLEAVED_BITPLANE_TO_CHUNKY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IBPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ibpc assertion failed");

// Next-cycle implication, disabled during reset.
`define IBPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ibpc assertion failed");

`endif

// ===== design/ibpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ibpc_pkg
// Types, constants and helpers shared by the bitplane to chunky modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibpc_pkg;

	localparam int MAX_PLANES_DEFAULT      = 4;
	localparam int PIXELS_PER_WORD_DEFAULT = 16;

	localparam int ROW_WIDTH_LOW  = 320;
	localparam int ROW_WIDTH_HIGH = 640;

	// Index slots of a chunky pixel; one plane word per slot.
	localparam int PLANE_SLOTS  = 4;
	localparam int PLANE_CNT_W  = 3;
	localparam int PLANE_POS_W  = 2;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [1:0] MODE_FOUR_PLANE = 2'd0;
	localparam logic [1:0] MODE_TWO_PLANE  = 2'd1;
	localparam logic [1:0] MODE_ONE_PLANE  = 2'd2;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [PLANE_CNT_W-1:0] mode_planes(
		input logic [1:0] mode,
		input int         max_planes
	);
		logic [PLANE_CNT_W-1:0] p;
		unique case (mode)
			MODE_FOUR_PLANE: p = PLANE_CNT_W'(4);
			MODE_TWO_PLANE:  p = PLANE_CNT_W'(2);
			MODE_ONE_PLANE:  p = PLANE_CNT_W'(1);
			default:         p = PLANE_CNT_W'(1);
		endcase
		if (int'(p) > max_planes) begin
			p = PLANE_CNT_W'(max_planes);
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== design/ibpc_front.sv =====
// ----------------------------------------------------------------------------
// ibpc_front
// Accepts plane words, holds the earlier words of a group and hands each
// complete group, with its end-of-row flag, to the group queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibpc_front
	import ibpc_pkg::*;
#(
	parameter int MAX_PLANES      = MAX_PLANES_DEFAULT,
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEFAULT
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     resolution_mode_we,
	input  wire logic [1:0]                               resolution_mode,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic [PIXELS_PER_WORD-1:0]               plane_word,
	input  wire q_stat_t                                  q_stat,
	output logic                                          push,
	output logic [PLANE_SLOTS*PIXELS_PER_WORD:0]          push_data
);

	localparam int HeldDepth  = (MAX_PLANES >= PLANE_SLOTS) ? PLANE_SLOTS - 1 :
		((MAX_PLANES > 1) ? MAX_PLANES - 1 : 1);
	localparam int GroupsLow  = ROW_WIDTH_LOW / PIXELS_PER_WORD;
	localparam int GroupsHigh = ROW_WIDTH_HIGH / PIXELS_PER_WORD;
	localparam int GroupW     = $clog2(GroupsHigh);

	logic [1:0]                           mode_q;
	logic [PLANE_POS_W-1:0]               plane_pos_q;
	logic [GroupW-1:0]                    group_q;
	logic [HeldDepth-1:0][PIXELS_PER_WORD-1:0] held_q;

	logic [PLANE_CNT_W-1:0]               planes;
	logic [GroupW-1:0]                    group_end;
	logic                                 accept;
	logic                                 last_plane;
	logic                                 row_end;
	logic [PLANE_SLOTS-1:0][PIXELS_PER_WORD-1:0] slots;

	assign planes     = mode_planes(mode_q, MAX_PLANES);
	assign group_end  = (mode_q == MODE_FOUR_PLANE) ? GroupW'(GroupsLow - 1) :
		GroupW'(GroupsHigh - 1);
	assign in_stall   = q_stat.full;
	assign accept     = in_valid && !in_stall;
	assign last_plane = ({1'b0, plane_pos_q} + PLANE_CNT_W'(1)) >= planes;
	assign row_end    = group_q >= group_end;
	assign push       = accept && last_plane;

	always_comb begin
		for (int k = 0; k < PLANE_SLOTS; k++) begin
			if (k == int'(planes) - 1) begin
				slots[k] = plane_word;
			end else if (k < int'(planes) - 1 && k < HeldDepth) begin
				slots[k] = held_q[k];
			end else begin
				slots[k] = '0;
			end
		end
	end

	assign push_data = {row_end, slots};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FOUR_PLANE;
			plane_pos_q <= '0;
			group_q     <= '0;
		end else if (resolution_mode_we) begin
			mode_q      <= resolution_mode;
			plane_pos_q <= '0;
			group_q     <= '0;
		end else if (accept) begin
			if (last_plane) begin
				plane_pos_q <= '0;
				group_q     <= row_end ? '0 : group_q + GroupW'(1);
			end else begin
				plane_pos_q <= plane_pos_q + PLANE_POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < HeldDepth; j++) begin
			if (accept && !last_plane && int'(plane_pos_q) == j) begin
				held_q[j] <= plane_word;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/ibpc_queue.sv =====
// ----------------------------------------------------------------------------
// ibpc_queue
// Short first-in first-out queue of complete plane groups between the
// front and the pixel serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibpc_queue
	import ibpc_pkg::*;
#(
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire logic [PLANE_SLOTS*PIXELS_PER_WORD:0] push_data,
	input  wire logic                                 pop,
	output logic [PLANE_SLOTS*PIXELS_PER_WORD:0]      head,
	output q_stat_t                                   q_stat
);

	`include "interleaved_bitplane_to_chunky_top_assert.svh"

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic [PLANE_SLOTS*PIXELS_PER_WORD:0] mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]                      wr_ptr_q;
	logic [PtrW-1:0]                      rd_ptr_q;
	logic [CntW-1:0]                      count_q;

	assign q_stat.empty = count_q == '0;
	assign q_stat.full  = count_q == CntW'(QUEUE_DEPTH);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`IBPC_ASSERT_NOW(a_q_no_overflow, clk, arst_n, push, !q_stat.full)
	`IBPC_ASSERT_NOW(a_q_no_underflow, clk, arst_n, pop, !q_stat.empty)
	`IBPC_ASSERT_NEXT(a_q_push_not_empty, clk, arst_n, push && !pop, !q_stat.empty)

endmodule

`default_nettype wire

// ===== design/ibpc_back.sv =====
// ----------------------------------------------------------------------------
// ibpc_back
// Takes one plane group at a time from the queue and sends out its chunky
// pixels, leftmost first, through an output register, one per cycle while groups are queued and out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibpc_back
	import ibpc_pkg::*;
#(
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [PLANE_SLOTS*PIXELS_PER_WORD:0] head,
	input  wire q_stat_t                              q_stat,
	output logic                                      pop,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [PLANE_SLOTS-1:0]                    pixel_index,
	output logic                                      group_last,
	output logic                                      row_last
);

	`include "interleaved_bitplane_to_chunky_top_assert.svh"

	localparam int CntW = $clog2(PIXELS_PER_WORD);

	logic                                          busy_q;
	logic [CntW-1:0]                               cnt_q;
	logic                                          row_end_q;
	logic [PLANE_SLOTS-1:0][PIXELS_PER_WORD-1:0]   words_q;
	logic                                          out_valid_q;
	logic [PLANE_SLOTS-1:0]                        pixel_index_q;
	logic                                          group_last_q;
	logic                                          row_last_q;

	logic                                          advance;
	logic                                          last_pix;
	logic [PLANE_SLOTS-1:0]                        pix;

	assign advance  = busy_q && (!out_valid_q || !out_stall);
	assign last_pix = cnt_q == CntW'(PIXELS_PER_WORD - 1);
	assign pop      = !q_stat.empty && (!busy_q || (advance && last_pix));

	always_comb begin
		for (int k = 0; k < PLANE_SLOTS; k++) begin
			pix[k] = words_q[k][PIXELS_PER_WORD-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (advance) begin
				busy_q <= !last_pix;
				cnt_q  <= cnt_q + CntW'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_end_q <= head[PLANE_SLOTS*PIXELS_PER_WORD];
			words_q   <= head[PLANE_SLOTS*PIXELS_PER_WORD-1:0];
		end else if (advance) begin
			for (int k = 0; k < PLANE_SLOTS; k++) begin
				words_q[k] <= words_q[k] << 1;
			end
		end
		if (advance) begin
			pixel_index_q <= pix;
			group_last_q  <= last_pix;
			row_last_q    <= last_pix && row_end_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign group_last  = group_last_q;
	assign row_last    = row_last_q;

	`IBPC_ASSERT_NEXT(a_back_group_end, clk, arst_n, advance && last_pix, out_valid_q && group_last_q)
	`IBPC_ASSERT_NOW(a_back_row_in_group, clk, arst_n, out_valid_q && row_last_q, group_last_q)
	`IBPC_ASSERT_NOW(a_back_pop_when_free, clk, arst_n, pop && busy_q, advance && last_pix)

endmodule

`default_nettype wire

// ===== design/interleaved_bitplane_to_chunky_top.sv =====
// Converts word-interleaved bitplane words into chunky pixel indices. Pixels leave at one per
// cycle through a single output register while groups are queued and out_stall is low. A group
// of PIXELS_PER_WORD pixels is built from four, two or one plane words in four-, two- and
// one-plane mode. A word is accepted every cycle while the two-entry group queue has room; a
// complete group then passes through the group queue, the serializer word register and the output register.
// ----------------------------------------------------------------------------
// interleaved_bitplane_to_chunky_top
// Top level: plane word front end, group queue and pixel serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interleaved_bitplane_to_chunky_top
	import ibpc_pkg::*;
#(
	parameter int MAX_PLANES      = MAX_PLANES_DEFAULT,
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       resolution_mode_we,
	input  wire logic [1:0]                 resolution_mode,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [PIXELS_PER_WORD-1:0] plane_word,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [PLANE_SLOTS-1:0]          pixel_index,
	output logic                            group_last,
	output logic                            row_last
);

	q_stat_t                              q_stat;
	logic                                 push;
	logic                                 pop;
	logic [PLANE_SLOTS*PIXELS_PER_WORD:0] push_data;
	logic [PLANE_SLOTS*PIXELS_PER_WORD:0] head;

	ibpc_front #(
		.MAX_PLANES      (MAX_PLANES),
		.PIXELS_PER_WORD (PIXELS_PER_WORD)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.resolution_mode_we (resolution_mode_we),
		.resolution_mode    (resolution_mode),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.plane_word         (plane_word),
		.q_stat             (q_stat),
		.push               (push),
		.push_data          (push_data)
	);

	ibpc_queue #(
		.PIXELS_PER_WORD (PIXELS_PER_WORD)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	ibpc_back #(
		.PIXELS_PER_WORD (PIXELS_PER_WORD)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.group_last  (group_last),
		.row_last    (row_last)
	);

endmodule

`default_nettype wire
